// ===== design/lbc_pkg.sv =====
// Shared types, constants and codes for the LED blink-code event sequencer.
`timescale 1ns / 1ps
package lbc_pkg;

    // Default queue depth; the ring holds one fewer event than this.
    localparam int QUEUE_DEPTH_DEF = 8;

    // Field widths
    localparam int TYPE_W   = 4;
    localparam int VALUE_W  = 4;
    localparam int ENTRY_W  = TYPE_W + VALUE_W;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Type clamp and value encoding
    localparam logic [TYPE_W-1:0]  TYPE_MIN  = 4'd1;
    localparam logic [TYPE_W-1:0]  TYPE_MAX  = 4'd15;
    localparam logic [7:0]         VALUE_MAX = 8'd7;
    localparam logic [VALUE_W-1:0] NO_VALUE  = 4'hF;

    // Register reset values
    localparam logic [CFG_W-1:0] PULSE_SPACING_RST = 16'd20;
    localparam logic [CFG_W-1:0] STAGE_GAP_RST     = 16'd40;
    localparam logic [CFG_W-1:0] EVENT_GAP_RST     = 16'd80;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SPACING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_GAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_GAP     = 2'd2;

    // Action codes
    localparam logic [1:0] ACT_LOG    = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // Timing registers
    typedef struct packed {
        logic [CFG_W-1:0] pulse_spacing;
        logic [CFG_W-1:0] stage_gap;
        logic [CFG_W-1:0] event_gap;
    } t_cfg;

    // Oldest queued event, as seen by the sequencer
    typedef struct packed {
        logic               avail;
        logic [TYPE_W-1:0]  etype;
        logic [VALUE_W-1:0] evalue;
    } t_head;

    // Per-word commands to the sequencer
    typedef struct packed {
        logic tick;
        logic toggle;
    } t_seq_cmd;

    // Sequencer levels after the current word
    typedef struct packed {
        logic led;
        logic busy;
    } t_seq_status;

endpackage

// ===== design/lbc_ram.sv =====
// Generic single-port-write, registered-read RAM (read returns old data on collision).
`timescale 1ns / 1ps
module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lbc_queue.sv =====
// Event ring queue: pointers, storage RAM and head prefetch with write forwarding.
`timescale 1ns / 1ps
module lbc_queue #(
    parameter int QUEUE_DEPTH = lbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_type,
    input  logic [7:0]    i_value,
    input  logic          i_pop,
    output logic          o_dropped,
    output lbc_pkg::t_head o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic             full, empty, wr_en;

    logic [lbc_pkg::TYPE_W-1:0]  ctype;
    logic [lbc_pkg::VALUE_W-1:0] cvalue;
    logic [lbc_pkg::ENTRY_W-1:0] wr_word, rd_word, head_word;

    logic                        r_fwd_valid;
    logic [lbc_pkg::ENTRY_W-1:0] r_fwd_word;

    // Pointer arithmetic, wrapping at the depth
    assign wp_inc = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_inc = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign full   = (wp_inc == r_rp);
    assign empty  = (r_wp == r_rp);

    assign wr_en     = i_push && !full;
    assign o_dropped = i_push && full;

    // Clamp type to 1..15; values above 7 mean no value stage
    always_comb begin
        if (i_type == 8'd0) begin
            ctype = lbc_pkg::TYPE_MIN;
        end else if (i_type > 8'(lbc_pkg::TYPE_MAX)) begin
            ctype = lbc_pkg::TYPE_MAX;
        end else begin
            ctype = i_type[lbc_pkg::TYPE_W-1:0];
        end
        if (i_value <= lbc_pkg::VALUE_MAX) begin
            cvalue = i_value[lbc_pkg::VALUE_W-1:0];
        end else begin
            cvalue = lbc_pkg::NO_VALUE;
        end
    end

    assign wr_word = {ctype, cvalue};
    assign n_wp    = wr_en ? wp_inc : r_wp;
    assign n_rp    = (i_pop && !empty) ? rp_inc : r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            // catch a write into the slot being prefetched this edge
            r_fwd_valid <= wr_en && (r_wp == n_rp);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_word <= wr_word;
    end

    // Read address is the next read pointer so the head word is ready each cycle
    lbc_ram #(
        .WIDTH (lbc_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_wp),
        .i_wdata (wr_word),
        .i_raddr (n_rp),
        .o_rdata (rd_word)
    );

    assign head_word     = r_fwd_valid ? r_fwd_word : rd_word;
    assign o_head.avail  = !empty;
    assign o_head.etype  = head_word[lbc_pkg::ENTRY_W-1:lbc_pkg::VALUE_W];
    assign o_head.evalue = head_word[lbc_pkg::VALUE_W-1:0];

endmodule

// ===== design/lbc_seq.sv =====
// Blink sequencer: time base, pulse stages, gaps and LED level.
`timescale 1ns / 1ps
module lbc_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lbc_pkg::t_seq_cmd    i_cmd,
    input  lbc_pkg::t_cfg        i_cfg,
    input  lbc_pkg::t_head       i_head,
    output logic                 o_pop,
    output lbc_pkg::t_seq_status o_status
);

    localparam int TW = lbc_pkg::TIME_W;

    logic          r_active, n_active;
    logic          r_vstage, n_vstage;
    logic [3:0]    r_pulses, n_pulses;
    logic [3:0]    r_vpend,  n_vpend;
    logic [TW-1:0] r_next,   n_next;
    logic [TW-1:0] r_idle,   n_idle;
    logic [TW-1:0] r_time,   n_time;
    logic          r_led,    n_led;
    logic [3:0]    pulses_dec;

    assign pulses_dec = r_pulses - 1'b1;

    // One sequencer step per tick, then the time base advances
    always_comb begin
        n_active = r_active;
        n_vstage = r_vstage;
        n_pulses = r_pulses;
        n_vpend  = r_vpend;
        n_next   = r_next;
        n_idle   = r_idle;
        n_time   = r_time;
        n_led    = r_led;
        o_pop    = 1'b0;
        if (i_cmd.tick) begin
            n_time = r_time + 1'b1;
            if (!r_active) begin
                // start the oldest event once the idle gap is over
                if (r_time >= r_idle && i_head.avail) begin
                    o_pop    = 1'b1;
                    n_pulses = i_head.etype;
                    n_vpend  = (i_head.evalue == lbc_pkg::NO_VALUE) ? 4'd0
                                                                   : i_head.evalue + 1'b1;
                    n_active = 1'b1;
                    n_vstage = 1'b0;
                    n_next   = r_time;
                    n_led    = 1'b1;
                end
            end else if (r_time >= r_next && r_pulses != 4'd0) begin
                n_led    = !r_led;
                n_pulses = pulses_dec;
                n_next   = r_time + TW'(i_cfg.pulse_spacing);
                if (pulses_dec == 4'd0) begin
                    n_led = 1'b0;
                    if (!r_vstage && r_vpend != 4'd0) begin
                        // move on to the value stage
                        n_vstage = 1'b1;
                        n_pulses = r_vpend;
                        n_vpend  = 4'd0;
                        n_next   = r_time + TW'(i_cfg.stage_gap);
                    end else begin
                        n_active = 1'b0;
                        n_vstage = 1'b0;
                        n_idle   = r_time + TW'(i_cfg.event_gap);
                    end
                end
            end
        end else if (i_cmd.toggle) begin
            n_led = !r_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_vstage <= 1'b0;
            r_pulses <= '0;
            r_vpend  <= '0;
            r_next   <= '0;
            r_idle   <= '0;
            r_time   <= '0;
            r_led    <= 1'b1;
        end else begin
            r_active <= n_active;
            r_vstage <= n_vstage;
            r_pulses <= n_pulses;
            r_vpend  <= n_vpend;
            r_next   <= n_next;
            r_idle   <= n_idle;
            r_time   <= n_time;
            r_led    <= n_led;
        end
    end

    // Levels as they stand after this word
    assign o_status.led  = n_led;
    assign o_status.busy = n_active;

endmodule

// ===== design/led_blink_code_event_sequencer_core.sv =====
// Top level of the LED blink-code event sequencer: handshakes, registers, result word.
`timescale 1ns / 1ps
// Takes one input word per clock while results are taken, and returns exactly one result
// word for each (LED level, drop flag, busy flag after that word). A log word
// queues an event in a RAM ring that holds QUEUE_DEPTH-1 events; the head entry
// is prefetched through the RAM's registered read port with write forwarding,
// so a tick can start the next event in the same cycle. Ticks step the blink
// sequencer and the 32-bit millisecond count; a toggle word flips the LED.
// The result register lets a new word in while the previous result is taken.
// Reset needs no clearing pass. The user must write registers only while idle (not enforced).
module led_blink_code_event_sequencer_core #(
    parameter int QUEUE_DEPTH = lbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input word
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [15:0]                     i_s_tdata,  // [7:0] event_type, [15:8] event_value
    input  logic [1:0]                      i_s_tuser,  // [1:0] action
    // result word
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata,  // [0] led_on, [1] event_dropped,
                                                        // [2] sequence_busy, [7:3] zero
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0]       i_cfg_data
);

    logic                 accept;
    logic                 push, dropped, pop;
    lbc_pkg::t_cfg        r_cfg;
    lbc_pkg::t_head       head;
    lbc_pkg::t_seq_cmd    cmd;
    lbc_pkg::t_seq_status status;

    logic       r_out_valid;
    logic [2:0] r_out_bits;

    // Input is taken whenever the result slot is free or draining
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Decode action
    always_comb begin
        push       = 1'b0;
        cmd.tick   = 1'b0;
        cmd.toggle = 1'b0;
        case (i_s_tuser)
            lbc_pkg::ACT_LOG:    push       = accept;
            lbc_pkg::ACT_TICK:   cmd.tick   = accept;
            lbc_pkg::ACT_TOGGLE: cmd.toggle = accept;
            lbc_pkg::ACT_NONE:   ;
            default:             ;
        endcase
    end

    // Timing registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_spacing <= lbc_pkg::PULSE_SPACING_RST;
            r_cfg.stage_gap     <= lbc_pkg::STAGE_GAP_RST;
            r_cfg.event_gap     <= lbc_pkg::EVENT_GAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lbc_pkg::CFG_PULSE_SPACING: r_cfg.pulse_spacing <= i_cfg_data;
                lbc_pkg::CFG_STAGE_GAP:     r_cfg.stage_gap     <= i_cfg_data;
                lbc_pkg::CFG_EVENT_GAP:     r_cfg.event_gap     <= i_cfg_data;
                default:                    ;
            endcase
        end
    end

    lbc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_type    (i_s_tdata[7:0]),
        .i_value   (i_s_tdata[15:8]),
        .i_pop     (pop),
        .o_dropped (dropped),
        .o_head    (head)
    );

    lbc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .o_pop    (pop),
        .o_status (status)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_bits <= {status.busy, dropped, status.led};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_bits};

endmodule
